@@ src/bvrf_pkg.sv @@
// Package for the banked vector register file mapper.
// Holds request and result payload types, action codes and command codes.
// No dependencies.
package bvrf_pkg;

  // Action codes of one input request
  localparam logic [2:0] ACT_ELEM_RD = 3'd0;
  localparam logic [2:0] ACT_ELEM_WR = 3'd1;
  localparam logic [2:0] ACT_LDU_RD  = 3'd2;
  localparam logic [2:0] ACT_LDU_WR  = 3'd3;
  localparam logic [2:0] ACT_MASK_RD = 3'd4;
  localparam logic [2:0] ACT_BYTE_RD = 3'd5;
  localparam logic [2:0] ACT_BYTE_WR = 3'd6;

  // Store operation carried from front to back
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_MASK  = 2'd3;

  // Word address width that covers the largest store (64 x 16 x 1024 x 2 words)
  localparam int CMD_ADDR_W = 21;

  typedef struct packed {
    logic [2:0]  action;
    logic [6:0]  head_line;
    logic [13:0] elem_index;
    logic        elem_is_16bit;
    logic [13:0] byte_offset;
    logic [15:0] write_value;
  } bvrf_in_t;

  typedef struct packed {
    logic [15:0] read_value;
    logic        mask_set;
  } bvrf_out_t;

  // Mapped store command: CMD_ADDR_W-bit (21-bit) word address plus byte select
  typedef struct packed {
    logic [1:0]            op;
    logic                  wide;
    logic                  bsel;
    logic [CMD_ADDR_W-1:0] addr;
    logic [15:0]           wdata;
  } bvrf_cmd_t;

endpackage

@@ src/bvrf_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
module bvrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/bvrf_fifo.sv @@
// Small generic register queue with occupancy count.
// No dependencies.
module bvrf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             push_ok, pop_ok;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // payload slots need no reset
  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ src/bvrf_front.sv @@
// Front end: decodes a request and maps it to a store word address.
// Depends on bvrf_pkg.
module bvrf_front
  import bvrf_pkg::*;
#(
  parameter int LANES = 16,
  parameter int BANKS = 4,
  parameter int LINES = 128
) (
  input  bvrf_in_t  req,
  output bvrf_cmd_t cmd
);

  localparam int LW = $clog2(LANES);
  localparam int BW = $clog2(BANKS);
  localparam int NW = $clog2(LINES);
  localparam int DATA_WORDS = LANES * BANKS * LINES;
  localparam logic [15:0] LANE_M = 16'(LANES - 1);
  localparam logic [15:0] BANK_M = 16'(BANKS - 1);
  localparam logic [15:0] LINE_M = 16'(LINES - 1);
  localparam logic [15:0] LBYTE_M = 16'(2 * BANKS - 1);

  logic [15:0] idx, head, la;
  logic        w16;

  // element and mask layouts share a per-entry index
  logic [15:0] e, e_lane, e_lbank, e_row, e_bank, e_line;
  logic        e_b;
  // load-unit layout
  logic [15:0] bi, u_word, u_lane, u_inl, u_enc, u_bank, u_line;
  // logical byte layout
  logic [15:0] g_lane, g_lbank, g_row, g_bank;
  // mask layout
  logic [15:0] m_row;

  logic [CMD_ADDR_W-1:0] elem_word, ldu_word, byte_word, mask_word;

  assign idx  = 16'(req.elem_index);
  assign head = 16'(req.head_line);
  assign la   = 16'(req.byte_offset);
  assign w16  = req.elem_is_16bit;

  // element layout: bank rotated by row plus head line
  assign e       = w16 ? idx : (idx >> 1);
  assign e_b     = w16 ? 1'b0 : idx[0];
  assign e_lane  = (e >> BW) & LANE_M;
  assign e_lbank = e & BANK_M;
  assign e_row   = e >> (BW + LW);
  assign e_bank  = (e_lbank + e_row + head) & BANK_M;
  assign e_line  = (head + e_row) & LINE_M;
  assign elem_word = (CMD_ADDR_W'(e_lane) << (BW + NW)) | (CMD_ADDR_W'(e_bank) << NW)
                   | CMD_ADDR_W'(e_line);

  // load-unit layout: lane-major words, bank rotated by encoded word address
  assign bi     = w16 ? (idx << 1) : idx;
  assign u_word = bi >> (LW + BW + 1);
  assign u_lane = (bi >> (BW + 1)) & LANE_M;
  assign u_inl  = bi & LBYTE_M;
  assign u_enc  = head + u_word;
  assign u_bank = ((u_inl >> 1) + u_enc) & BANK_M;
  assign u_line = u_enc & LINE_M;
  assign ldu_word = (CMD_ADDR_W'(u_lane) << (BW + NW)) | (CMD_ADDR_W'(u_bank) << NW)
                  | CMD_ADDR_W'(u_line);

  // logical byte layout: bank rotated by row
  assign g_lbank = (la >> 1) & BANK_M;
  assign g_lane  = (la >> (BW + 1)) & LANE_M;
  assign g_row   = (la >> (BW + LW + 1)) & LINE_M;
  assign g_bank  = (g_lbank + g_row) & BANK_M;
  assign byte_word = (CMD_ADDR_W'(g_lane) << (BW + NW)) | (CMD_ADDR_W'(g_bank) << NW)
                   | CMD_ADDR_W'(g_row);

  // mask layout: unrotated, in the upper half of the store
  assign m_row = e_row & LINE_M;
  assign mask_word = CMD_ADDR_W'(DATA_WORDS) + (CMD_ADDR_W'(e_lane) << (BW + NW))
                   + (CMD_ADDR_W'(m_row) << BW) + CMD_ADDR_W'(e_lbank);

  // classify the action
  always_comb begin
    cmd.op    = OP_NONE;
    cmd.wide  = 1'b0;
    cmd.bsel  = 1'b0;
    cmd.addr  = '0;
    cmd.wdata = req.write_value;
    case (req.action)
      ACT_ELEM_RD, ACT_ELEM_WR: begin
        cmd.op   = (req.action == ACT_ELEM_WR) ? OP_WRITE : OP_READ;
        cmd.wide = w16;
        cmd.bsel = e_b;
        cmd.addr = elem_word;
      end
      ACT_LDU_RD, ACT_LDU_WR: begin
        cmd.op   = (req.action == ACT_LDU_WR) ? OP_WRITE : OP_READ;
        cmd.wide = w16;
        cmd.bsel = u_inl[0];
        cmd.addr = ldu_word;
      end
      ACT_MASK_RD: begin
        cmd.op   = OP_MASK;
        cmd.wide = w16;
        cmd.bsel = e_b;
        cmd.addr = mask_word;
      end
      ACT_BYTE_RD, ACT_BYTE_WR: begin
        cmd.op   = (req.action == ACT_BYTE_WR) ? OP_WRITE : OP_READ;
        cmd.bsel = la[0];
        cmd.addr = byte_word;
      end
      default: begin
        cmd.op = OP_NONE;
      end
    endcase
  end

endmodule

@@ src/bvrf_back.sv @@
// Back end: executes mapped commands on the byte store and queues results.
// Depends on bvrf_pkg, bvrf_ram and bvrf_fifo.
module bvrf_back
  import bvrf_pkg::*;
#(
  parameter int LANES     = 16,
  parameter int BANKS     = 4,
  parameter int LINES     = 128,
  parameter int RES_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  bvrf_cmd_t cmd,
  output logic      cmd_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output bvrf_out_t out_data
);

  localparam int WORDS = 2 * LANES * BANKS * LINES;
  localparam int AW    = $clog2(WORDS);
  localparam int CW    = $clog2(RES_DEPTH + 1);

  logic [AW-1:0] ram_addr;
  logic          we_even, we_odd;
  logic [7:0]    rd_even, rd_odd;
  logic [7:0]    wd_odd;

  // access stage tracking the cycle of the RAM read
  logic          valid_r;
  logic [1:0]    op_r;
  logic          wide_r, bsel_r;

  logic [CW-1:0] res_count;
  logic          res_full;
  logic [CW:0]   pending;
  logic [7:0]    sel_byte;
  bvrf_out_t     res;

  // issue only while the result queue has room for everything in flight
  assign pending = {1'b0, res_count} + {{CW{1'b0}}, valid_r};
  assign cmd_pop = cmd_valid && (pending < (CW + 1)'(RES_DEPTH));

  // byte lanes: even byte in one RAM, odd byte in the other
  assign ram_addr = cmd.addr[AW-1:0];
  assign we_even  = cmd_pop && (cmd.op == OP_WRITE) && (cmd.wide || !cmd.bsel);
  assign we_odd   = cmd_pop && (cmd.op == OP_WRITE) && (cmd.wide || cmd.bsel);
  assign wd_odd   = cmd.wide ? cmd.wdata[15:8] : cmd.wdata[7:0];

  bvrf_ram #(.WIDTH(8), .DEPTH(WORDS)) u_ram_even (
    .clk   (clk),
    .we    (we_even),
    .addr  (ram_addr),
    .wdata (cmd.wdata[7:0]),
    .rdata (rd_even)
  );

  bvrf_ram #(.WIDTH(8), .DEPTH(WORDS)) u_ram_odd (
    .clk   (clk),
    .we    (we_odd),
    .addr  (ram_addr),
    .wdata (wd_odd),
    .rdata (rd_odd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      op_r   <= cmd.op;
      wide_r <= cmd.wide;
      bsel_r <= cmd.bsel;
    end
  end

  // shape the result from the read bytes
  assign sel_byte = bsel_r ? rd_odd : rd_even;

  always_comb begin
    res.read_value = '0;
    res.mask_set   = 1'b0;
    case (op_r)
      OP_READ: begin
        res.read_value = wide_r ? {rd_odd, rd_even} : {8'h00, sel_byte};
      end
      OP_MASK: begin
        res.mask_set = wide_r ? |(rd_odd & rd_even) : |sel_byte;
      end
      default: begin
        res.read_value = '0;
      end
    endcase
  end

  bvrf_fifo #(.WIDTH($bits(bvrf_out_t)), .DEPTH(RES_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (valid_r),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_data),
    .empty (out_empty),
    .count (res_count)
  );

  // the issue check keeps the queue from overflowing; full is unused otherwise
  logic unused_full;
  assign unused_full = res_full;

endmodule

@@ src/banked_vector_register_file_mapper_top.sv @@
// Top level of the banked vector register file mapper.
// Depends on bvrf_pkg, bvrf_front, bvrf_fifo and bvrf_back.
//
// Usage:
//   Requests enter on a queue-style port: in_data is taken at a rising edge
//   where in_push is high and in_full is low. Each request is one access to
//   the byte store (element, load-unit, mask or logical byte layout).
//   Every request yields exactly one result, in order, on out_data while
//   out_empty is low; it is taken at an edge where out_pop is high.
//   Writes and the unused action code return zeros.
// Timing:
//   A result passes the command queue, the registered read port of the store
//   and the result queue. Throughput is one request per cycle while results
//   are popped, set by the single port of each store byte RAM.
// Reset and stalls:
//   Synchronous active-low reset empties both queues; store contents are
//   undefined until written. When the receiver stops popping, the result
//   queue fills, the back end stops issuing, the command queue fills and
//   in_full rises; nothing is dropped.
module banked_vector_register_file_mapper_top
  import bvrf_pkg::*;
#(
  parameter int LANES = 16,
  parameter int BANKS = 4,
  parameter int LINES = 128
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  bvrf_in_t  in_data,
  output logic      out_empty,
  input  logic      out_pop,
  output bvrf_out_t out_data
);

  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 4;

  bvrf_cmd_t front_cmd, back_cmd;
  logic      cmd_empty, cmd_pop;
  logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;

  // map the request to a store command
  bvrf_front #(.LANES(LANES), .BANKS(BANKS), .LINES(LINES)) u_front (
    .req (in_data),
    .cmd (front_cmd)
  );

  // decoupling queue between front and back
  bvrf_fifo #(.WIDTH($bits(bvrf_cmd_t)), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (front_cmd),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (back_cmd),
    .empty (cmd_empty),
    .count (cmd_count)
  );

  // store access and result queue
  bvrf_back #(
    .LANES(LANES), .BANKS(BANKS), .LINES(LINES), .RES_DEPTH(RES_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!cmd_empty),
    .cmd       (back_cmd),
    .cmd_pop   (cmd_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  // occupancy is tracked by the queue's own flags here
  logic unused_count;
  assign unused_count = ^cmd_count;

endmodule

@@ tb/banked_vector_register_file_mapper_top_test.sv @@
// Self-checking testbench for banked_vector_register_file_mapper_top.
// Holds a mapped byte store checker class plus request and result drivers.
// Depends on bvrf_pkg and the mapper top level.
module banked_vector_register_file_mapper_top_test;
  import bvrf_pkg::*;

  localparam int LANES = 16;
  localparam int BANKS = 4;
  localparam int LINES = 128;
  localparam int BANK_BYTES = LINES * 2;
  localparam int LANE_BYTES = BANKS * BANK_BYTES;
  localparam int DATA_BYTES = LANES * LANE_BYTES;
  localparam int STORE_BYTES = 2 * DATA_BYTES;

  // Code 7 has no store access and returns zeros
  localparam logic [2:0] ACT_UNUSED = 3'd7;

  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT = 3000;
  localparam int TAIL_CYCLES = 8;

  // Expected-result tracker: mirrors the byte store and the address layouts
  class mapped_store_checker;
    logic [7:0] store_bytes [STORE_BYTES];
    bit         was_written [STORE_BYTES];
    bvrf_out_t  pending_results [$];
    int         errors;
    int         by_action [8];
    int         reads_checked;

    function int unsigned phys(int unsigned lane, int unsigned bank,
                               int unsigned row, int unsigned b);
      return lane * LANE_BYTES + bank * BANK_BYTES + row * 2 + b;
    endfunction

    // Element layout: bank rotated by row plus head line
    function int unsigned elem_addr(int unsigned head, int unsigned idx, bit w16);
      int unsigned per_bank, per_row, in_row, row, lane, lbank, bank, b;
      per_bank = w16 ? 1 : 2;
      per_row = per_bank * BANKS * LANES;
      in_row = idx % per_row;
      row = idx / per_row;
      lane = (in_row / (per_bank * BANKS)) % LANES;
      lbank = (in_row / per_bank) % BANKS;
      bank = (lbank + row + head) % BANKS;
      b = w16 ? 0 : (in_row & 1);
      return phys(lane, bank, (head + row) % LINES, b);
    endfunction

    // Load-unit layout: lane-major words, bank rotated by the word address
    function int unsigned ldu_addr(int unsigned head, int unsigned idx, bit w16);
      int unsigned bi, word, in_word, lane, in_lane, enc, bank;
      bi = idx * (w16 ? 2 : 1);
      word = bi / (LANES * 2 * BANKS);
      in_word = bi % (LANES * 2 * BANKS);
      lane = in_word / (2 * BANKS);
      in_lane = in_word % (2 * BANKS);
      enc = head + word;
      bank = ((in_lane / 2) + (enc % BANKS)) % BANKS;
      return phys(lane, bank, enc % LINES, in_lane & 1);
    endfunction

    // Logical byte layout: byte, bank, lane, row; bank rotated by row
    function int unsigned byte_addr(int unsigned a);
      int unsigned lbank, lane, row;
      lbank = (a >> 1) % BANKS;
      lane = (a / (2 * BANKS)) % LANES;
      row = (a / (2 * BANKS * LANES)) % LINES;
      return phys(lane, (lbank + row) % BANKS, row, a & 1);
    endfunction

    // Mask layout: unrotated, above the data region
    function int unsigned mask_loc(int unsigned idx, bit w16);
      int unsigned per_bank, per_lane, lane, row, in_lane;
      per_bank = w16 ? 1 : 2;
      per_lane = per_bank * BANKS;
      lane = (idx / per_lane) % LANES;
      row = (idx / (per_lane * LANES)) % LINES;
      in_lane = (idx % per_lane) * (w16 ? 2 : 1);
      return DATA_BYTES + lane * LANE_BYTES + row * BANKS * 2 + in_lane;
    endfunction

    // First store byte and byte count that a request touches (count 0: none)
    function void map_access(bvrf_in_t r, output int unsigned addr,
                             output int unsigned nbytes);
      nbytes = r.elem_is_16bit ? 2 : 1;
      case (r.action)
        ACT_ELEM_RD, ACT_ELEM_WR: begin
          addr = elem_addr(32'(r.head_line), 32'(r.elem_index), r.elem_is_16bit);
        end
        ACT_LDU_RD, ACT_LDU_WR: begin
          addr = ldu_addr(32'(r.head_line), 32'(r.elem_index), r.elem_is_16bit);
        end
        ACT_MASK_RD: begin
          addr = mask_loc(32'(r.elem_index), r.elem_is_16bit);
        end
        ACT_BYTE_RD, ACT_BYTE_WR: begin
          addr = byte_addr(32'(r.byte_offset));
          nbytes = 1;
        end
        default: begin
          addr = 0;
          nbytes = 0;
        end
      endcase
      addr = addr % STORE_BYTES;
    endfunction

    function bit is_write(logic [2:0] act);
      return act == ACT_ELEM_WR || act == ACT_LDU_WR || act == ACT_BYTE_WR;
    endfunction

    // True when every byte the request would read has been written
    function bit can_read(bvrf_in_t r);
      int unsigned a, n;
      map_access(r, a, n);
      if (is_write(r.action) || n == 0) return 1'b1;
      return was_written[a] && (n == 1 || was_written[(a + 1) % STORE_BYTES]);
    endfunction

    // Accepted request: update the mirror and queue the expected result
    function void note_request(bvrf_in_t r);
      bvrf_out_t want;
      int unsigned a, n, a1;
      want = '0;
      by_action[r.action]++;
      map_access(r, a, n);
      a1 = (a + 1) % STORE_BYTES;
      if (is_write(r.action)) begin
        store_bytes[a] = r.write_value[7:0];
        was_written[a] = 1'b1;
        if (n == 2) begin
          store_bytes[a1] = r.write_value[15:8];
          was_written[a1] = 1'b1;
        end
      end else if (r.action == ACT_MASK_RD) begin
        want.mask_set = ((n == 2) ? (store_bytes[a] & store_bytes[a1])
                                  : store_bytes[a]) != 8'h00;
      end else if (n != 0) begin
        want.read_value = {(n == 2) ? store_bytes[a1] : 8'h00, store_bytes[a]};
        reads_checked++;
      end
      pending_results.push_back(want);
    endfunction

    task report(string what, bvrf_out_t got, bvrf_out_t want);
      $display("mismatch on %s: got value %h mask %b, want value %h mask %b",
               what, got.read_value, got.mask_set, want.read_value, want.mask_set);
      errors++;
    endtask

    // Accepted result: compare with the oldest expectation
    task check_result(bvrf_out_t got);
      bvrf_out_t want;
      if (pending_results.size() == 0) begin
        report("result with no request outstanding", got, '0);
        return;
      end
      want = pending_results.pop_front();
      if (got.read_value !== want.read_value) report("read_value", got, want);
      if (got.mask_set !== want.mask_set) report("mask_set", got, want);
    endtask
  endclass

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  bvrf_in_t  in_data = '0;
  logic      out_empty;
  logic      out_pop = 1'b0;
  bvrf_out_t out_data;

  mapped_store_checker sb;
  bvrf_in_t recent_writes [$];
  bit calm = 1'b0;
  bit hold_results = 1'b0;
  bit hold_active = 1'b0;
  int idle_cycles = 0;

  banked_vector_register_file_mapper_top #(
    .LANES(LANES),
    .BANKS(BANKS),
    .LINES(LINES)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Gap length: mostly none or short, sometimes long
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (calm || p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bvrf_in_t mk(logic [2:0] act, int head, int idx, bit w16,
                                  int la, logic [15:0] wv);
    bvrf_in_t r;
    r.action = act;
    r.head_line = 7'(head);
    r.elem_index = 14'(idx);
    r.elem_is_16bit = w16;
    r.byte_offset = 14'(la);
    r.write_value = wv;
    return r;
  endfunction

  // Random fields, mostly in a dense window so reads find written data
  function automatic bvrf_in_t rand_fields();
    bvrf_in_t r;
    bit wide;
    int hp;
    wide = ($urandom_range(0, 9) == 0);
    hp = $urandom_range(0, 7);
    r.action = ACT_UNUSED;
    if (wide) r.head_line = 7'($urandom_range(0, 127));
    else if (hp == 0) r.head_line = 7'($urandom_range(124, 127));
    else r.head_line = 7'($urandom_range(0, 3));
    r.elem_index = 14'(wide ? $urandom_range(0, 16383) : $urandom_range(0, 191));
    r.elem_is_16bit = 1'($urandom_range(0, 1));
    r.byte_offset = 14'(wide ? $urandom_range(0, 16383) : $urandom_range(0, 511));
    r.write_value = 16'($urandom_range(0, 65535));
    return r;
  endfunction

  function automatic logic [2:0] to_write(logic [2:0] act);
    case (act)
      ACT_ELEM_RD, ACT_MASK_RD: return ACT_ELEM_WR;
      ACT_LDU_RD: return ACT_LDU_WR;
      default: return ACT_BYTE_WR;
    endcase
  endfunction

  function automatic logic [2:0] to_read(logic [2:0] act);
    case (act)
      ACT_ELEM_WR: return ACT_ELEM_RD;
      ACT_LDU_WR: return ACT_LDU_RD;
      default: return ACT_BYTE_RD;
    endcase
  endfunction

  // Next random request; a read that would touch unwritten bytes becomes a write
  function automatic bvrf_in_t make_request();
    bvrf_in_t r;
    int pick, tries, k;
    r = rand_fields();
    pick = $urandom_range(0, 99);
    if (pick < 38) begin
      case ($urandom_range(0, 2))
        0: r.action = ACT_ELEM_WR;
        1: r.action = ACT_LDU_WR;
        default: r.action = ACT_BYTE_WR;
      endcase
    end else if (pick < 60 && recent_writes.size() != 0) begin
      // read back a recent write through the same layout
      k = $urandom_range(0, recent_writes.size() - 1);
      r = recent_writes[k];
      r.action = to_read(r.action);
      r.write_value = 16'($urandom_range(0, 65535));
    end else if (pick < 96) begin
      // any layout; mask bytes are never written, so mask reads fall through
      tries = 0;
      do begin
        r = rand_fields();
        case ($urandom_range(0, 7))
          0, 1, 2: r.action = ACT_ELEM_RD;
          3, 4: r.action = ACT_LDU_RD;
          5, 6: r.action = ACT_BYTE_RD;
          default: r.action = ACT_MASK_RD;
        endcase
        tries++;
      end while (!sb.can_read(r) && tries < 6);
      if (!sb.can_read(r)) r.action = to_write(r.action);
    end else begin
      r.action = ACT_UNUSED;
    end
    if (sb.is_write(r.action)) begin
      recent_writes.push_back(r);
      if (recent_writes.size() > 64) void'(recent_writes.pop_front());
    end
    return r;
  endfunction

  // Offer one request from a falling edge until taken, then idle for a random gap that may be zero
  task automatic send_request(bvrf_in_t r);
    int g;
    in_data <= r;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    @(negedge clk);
    g = pick_gap();
    if (g != 0) begin
      in_push <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    in_push <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic send_random(int count);
    repeat (count) send_request(make_request());
  endtask

  // Monitor: note accepted requests and check accepted results
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) sb.note_request(in_data);
    if (rst_n && out_pop && !out_empty) sb.check_result(out_data);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result receiver: random pop gaps, plus one long hold on request
  initial begin : receiver
    int g;
    @(negedge clk);
    forever begin
      if (hold_results) begin
        out_pop <= 1'b0;
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_active = 1'b0;
        hold_results = 1'b0;
      end
      out_pop <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      g = pick_gap();
      if (g != 0) begin
        out_pop <= 1'b0;
        repeat (g) @(negedge clk);
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    bvrf_in_t directed [$];
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: field extremes, row wrap, width views, byte actions, unused code.
    // Mask reads are left out: no action writes the mask region, so any mask
    // read would touch bytes that were never written.
    directed.push_back(mk(ACT_ELEM_WR, 0, 0, 1, 0, 16'hffff));
    directed.push_back(mk(ACT_ELEM_RD, 0, 0, 1, 0, 16'h0000));
    directed.push_back(mk(ACT_ELEM_RD, 0, 1, 0, 16383, 16'hffff));
    directed.push_back(mk(ACT_ELEM_WR, 127, 16383, 0, 0, 16'h00ab));
    directed.push_back(mk(ACT_ELEM_RD, 127, 16383, 0, 0, 16'h0000));
    directed.push_back(mk(ACT_LDU_WR, 127, 16383, 1, 0, 16'h8001));
    directed.push_back(mk(ACT_LDU_RD, 127, 16383, 1, 0, 16'h0000));
    directed.push_back(mk(ACT_LDU_WR, 0, 0, 0, 0, 16'h005a));
    directed.push_back(mk(ACT_LDU_RD, 0, 0, 0, 0, 16'h0000));
    directed.push_back(mk(ACT_BYTE_WR, 127, 16383, 1, 16383, 16'hffff));
    directed.push_back(mk(ACT_BYTE_RD, 0, 0, 1, 16383, 16'h0000));
    directed.push_back(mk(ACT_BYTE_WR, 0, 0, 0, 0, 16'h0000));
    directed.push_back(mk(ACT_BYTE_RD, 0, 0, 0, 0, 16'hffff));
    directed.push_back(mk(ACT_ELEM_RD, 0, 0, 1, 0, 16'h0000));
    directed.push_back(mk(ACT_UNUSED, 127, 16383, 1, 16383, 16'hffff));
    directed.push_back(mk(ACT_UNUSED, 0, 0, 0, 0, 16'h0000));
    foreach (directed[i]) send_request(directed[i]);
    drain();

    send_random(250);

    // Long receiver hold while requests keep coming, so the input stalls
    calm = 1'b1;
    hold_results = 1'b1;
    in_push <= 1'b0;
    while (!hold_active) @(negedge clk);
    while (hold_active) send_request(make_request());
    calm = 1'b0;
    drain();

    // Stretch without idling on either side
    calm = 1'b1;
    send_random(100);
    calm = 1'b0;

    send_random(200);

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("requests: %0d element, %0d load-unit, %0d byte, %0d unused code",
             sb.by_action[ACT_ELEM_RD] + sb.by_action[ACT_ELEM_WR],
             sb.by_action[ACT_LDU_RD] + sb.by_action[ACT_LDU_WR],
             sb.by_action[ACT_BYTE_RD] + sb.by_action[ACT_BYTE_WR],
             sb.by_action[ACT_UNUSED]);
    $display("%0d reads of written data checked, %0d mismatches",
             sb.reads_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
